// ===== design/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg - shared types and constants for the sorted table search
// Table geometry, field widths, opcodes, FSM states and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  // Table geometry
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Fixed field widths of the request and result channels
  localparam int OPC_W   = 1;
  localparam int EIDX_W  = 4;
  localparam int SKEY_W  = 16;
  localparam int PLD_W   = 16;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(10);

  // Width wide enough to compare entry_count against ENTRIES
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic write_entry;  // store key/payload from the request
    logic load_search;  // start a search: set bounds, read first probe
    logic step;         // narrow the bounds, read next probe
    logic finish;       // load the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic done;         // current probe is the final one
    logic out_free;     // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

// ===== design/stbs_in_if.sv =====
// ----------------------------------------------------------------------------
// stbs_in_if - request channel
// Valid/ready channel carrying one write or search request.
// ----------------------------------------------------------------------------
`default_nettype none

interface stbs_in_if;
  logic                           valid;
  logic                           ready;
  logic [stbs_pkg::OPC_W-1:0]     opcode;
  logic [stbs_pkg::EIDX_W-1:0]    entry_index;
  logic [stbs_pkg::SKEY_W-1:0]    search_key;
  logic [stbs_pkg::PLD_W-1:0]     entry_payload;

  modport source (output valid, opcode, entry_index, search_key, entry_payload,
                  input ready);
  modport sink   (input valid, opcode, entry_index, search_key, entry_payload,
                  output ready);
endinterface

`default_nettype wire

// ===== design/stbs_out_if.sv =====
// ----------------------------------------------------------------------------
// stbs_out_if - result channel
// Valid/ready channel carrying one search result.
// ----------------------------------------------------------------------------
`default_nettype none

interface stbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stbs_pkg::POS_W-1:0]   probe_position;
  logic [stbs_pkg::PLD_W-1:0]   result_payload;

  modport source (output valid, found, probe_position, result_payload,
                  input ready);
  modport sink   (input valid, found, probe_position, result_payload,
                  output ready);
endinterface

`default_nettype wire

// ===== design/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl - search controller
// Two-state FSM: takes requests while idle, steps the probe loop otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [stbs_pkg::OPC_W-1:0]    in_opcode,
  output logic                               in_ready,
  input  wire stbs_pkg::status_t             status,
  output stbs_pkg::cmd_t                     cmd
);

  stbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (in_valid && (in_opcode == stbs_pkg::OP_SEARCH)) begin
          state_nxt = stbs_pkg::ST_PROBE;
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (status.done && status.out_free) begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      stbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == stbs_pkg::OP_SEARCH) begin
            cmd.load_search = 1'b1;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (status.done) begin
          cmd.finish = status.out_free;  // hold while result reg is full
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/stbs_dp.sv =====
// ----------------------------------------------------------------------------
// stbs_dp - search datapath
// Key/payload table, search bounds, probe compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [stbs_pkg::CNT_W-1:0]    cfg_wdata,
  input  wire logic [stbs_pkg::EIDX_W-1:0]   in_entry_index,
  input  wire logic [stbs_pkg::SKEY_W-1:0]   in_search_key,
  input  wire logic [stbs_pkg::PLD_W-1:0]    in_entry_payload,
  input  wire stbs_pkg::cmd_t                cmd,
  output stbs_pkg::status_t                  status,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [stbs_pkg::POS_W-1:0]         out_probe_position,
  output logic [stbs_pkg::PLD_W-1:0]         out_result_payload
);

  localparam int IDX_W  = stbs_pkg::IDX_W;
  localparam int KB     = stbs_pkg::KEY_BITS;
  localparam int PW     = stbs_pkg::PLD_W;
  localparam int CMP_W  = stbs_pkg::CMP_W;
  localparam int ENT_W  = KB + PW;

  // config
  logic [stbs_pkg::CNT_W-1:0] entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= stbs_pkg::CNT_RESET;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // clamp count to 1..ENTRIES, initial high = count-1
  logic [CMP_W-1:0] count_c;
  logic [IDX_W-1:0] high_init;
  logic [IDX_W-1:0] mid_init;

  always_comb begin
    count_c = CMP_W'(entry_count_r);
    if (count_c == '0) begin
      count_c = CMP_W'(1);
    end else if (count_c > CMP_W'(stbs_pkg::ENTRIES)) begin
      count_c = CMP_W'(stbs_pkg::ENTRIES);
    end
    high_init = IDX_W'(count_c - CMP_W'(1));
    mid_init  = high_init >> 1;
  end

  // table: key in the upper bits, payload in the lower
  logic [ENT_W-1:0] mem [stbs_pkg::ENTRIES];
  logic [ENT_W-1:0] rd_r;
  logic             wr_ok;
  logic [IDX_W-1:0] rd_addr;

  assign wr_ok = ({{CMP_W{1'b0}}, in_entry_index} <
                  (CMP_W + stbs_pkg::EIDX_W)'(stbs_pkg::ENTRIES));

  always_ff @(posedge clk) begin
    if (cmd.write_entry && wr_ok) begin
      mem[IDX_W'(in_entry_index)] <= {KB'(in_search_key), in_entry_payload};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_search || cmd.step) begin
      rd_r <= mem[rd_addr];
    end
  end

  // search bounds
  logic [IDX_W-1:0] low_r, low_nxt;
  logic [IDX_W-1:0] high_r, high_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic [KB-1:0]    key_r;
  logic [KB-1:0]    rd_key;
  logic [IDX_W:0]   bound_sum;
  logic             key_eq;
  logic             key_gt;

  assign rd_key = rd_r[ENT_W-1:PW];
  assign key_eq = (rd_key == key_r);
  assign key_gt = (key_r > rd_key);

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (key_gt) begin
      low_nxt = IDX_W'(mid_r + IDX_W'(1));
    end else begin
      high_nxt = mid_r;
    end
    bound_sum = {1'b0, low_nxt} + {1'b0, high_nxt};
    mid_nxt   = bound_sum[IDX_W:1];
    rd_addr   = cmd.load_search ? mid_init : mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      low_r  <= '0;
      high_r <= high_init;
      mid_r  <= mid_init;
      key_r  <= KB'(in_search_key);
    end else if (cmd.step) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      mid_r  <= mid_nxt;
    end
  end

  // result register
  logic                        out_valid_r;
  logic                        found_r;
  logic [stbs_pkg::POS_W-1:0]  pos_r;
  logic [PW-1:0]               pld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found_r <= key_eq;
      pos_r   <= stbs_pkg::POS_W'(mid_r);
      pld_r   <= rd_r[PW-1:0];
    end
  end

  assign status.done     = key_eq || (low_r == high_r);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_found          = found_r;
  assign out_probe_position = pos_r;
  assign out_result_payload = pld_r;

endmodule

`default_nettype wire

// ===== design/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search - binary search over a key/payload table
// Write requests fill the table; search requests probe the first
// entry_count entries and return found, probe position and payload.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Carries
//  in_ch     in   valid/ready      opcode, entry_index, search_key, entry_payload
//  out_ch    out  valid/ready      found, probe_position, result_payload
//  cfg_*     in   write enable     entry_count (5 bits, reset 10)
//
//  Write request: stored in the table when accepted, no result.
//  Search request: accepted, then probes the table; up to
//    log2(ENTRIES)+1 probes, so 1..5 probes for 16 entries. The single
//    table read port does one read per probe.
//  Reset (rst_n low, synchronous) clears the FSM, result valid and
//    entry_count; table contents are left as they are.
//  A result waits in the output register; a new request is taken while it
//    waits, and a search finishing into a full register holds its last probe.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  stbs_in_if.sink                           in_ch,
  stbs_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [stbs_pkg::CNT_W-1:0]   cfg_wdata
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t status;

  // controller: request acceptance and probe loop sequencing
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: table, bounds, compare, result register
  stbs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_entry_index     (in_ch.entry_index),
    .in_search_key      (in_ch.search_key),
    .in_entry_payload   (in_ch.entry_payload),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_found          (out_ch.found),
    .out_probe_position (out_ch.probe_position),
    .out_result_payload (out_ch.result_payload)
  );

endmodule

`default_nettype wire
